// ===== rtl/core/krd_pkg.sv =====
package krd_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W    = 4;
  localparam int ID_W     = 32;
  localparam int PRICE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FIND       = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SET_PRICE  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_MAX        = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LIST_FWD   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LIST_BWD   = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_run;
    logic list_rd;
    logic list_emit;
    logic res_emit;
  } krd_ctrl_t;

  typedef struct packed {
    logic is_scan;
    logic is_list;
    logic empty;
    logic scan_done;
    logic list_last;
    logic out_free;
  } krd_stat_t;

endpackage

// ===== rtl/core/krd_in_if.sv =====
interface krd_in_if;
  logic                                valid;
  logic                                ready;
  logic [krd_pkg::CMD_W-1:0]           cmd;
  logic signed [krd_pkg::ID_W-1:0]     item_id;
  logic signed [krd_pkg::PRICE_W-1:0]  item_price;

  modport source (output valid, output cmd, output item_id, output item_price, input ready);
  modport sink   (input valid, input cmd, input item_id, input item_price, output ready);
endinterface

// ===== rtl/core/krd_out_if.sv =====
interface krd_out_if;
  logic                                valid;
  logic                                ready;
  logic [krd_pkg::STATUS_W-1:0]        status;
  logic signed [krd_pkg::ID_W-1:0]     out_id;
  logic signed [krd_pkg::PRICE_W-1:0]  out_price;
  logic [krd_pkg::COUNT_W-1:0]         record_count;
  logic                                last;

  modport source (output valid, output status, output out_id, output out_price,
                  output record_count, output last, input ready);
  modport sink   (input valid, input status, input out_id, input out_price,
                  input record_count, input last, output ready);
endinterface

// ===== rtl/core/krd_ctrl.sv =====
module krd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  krd_pkg::krd_stat_t  stat,
  output krd_pkg::krd_ctrl_t  ctrl
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_EXEC      = 6'b000010,
    S_SCAN      = 6'b000100,
    S_EMIT      = 6'b001000,
    S_LIST_RD   = 6'b010000,
    S_LIST_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        if (stat.is_scan && !stat.empty) begin
          state_next = S_SCAN;
        end else if (stat.is_list && !stat.empty) begin
          state_next = S_LIST_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        ctrl.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.res_emit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_LIST_RD: begin
        ctrl.list_rd = 1'b1;
        state_next   = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (stat.out_free) begin
          ctrl.list_emit = 1'b1;
          state_next     = stat.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/krd_datapath.sv =====
module krd_datapath #(
  parameter int DEPTH = krd_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [krd_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [krd_pkg::ID_W-1:0]     in_id,
  input  logic signed [krd_pkg::PRICE_W-1:0]  in_price,
  input  krd_pkg::krd_ctrl_t                  ctrl,
  output krd_pkg::krd_stat_t                  stat,
  krd_out_if.source                           out_ch
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [krd_pkg::ID_W-1:0]    key_mem   [DEPTH];
  logic [krd_pkg::PRICE_W-1:0] price_mem [DEPTH];

  logic [krd_pkg::CMD_W-1:0]    cmd_r;
  logic [krd_pkg::ID_W-1:0]     key_r;
  logic [krd_pkg::PRICE_W-1:0]  price_r;

  logic [IW-1:0] front;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;

  logic [krd_pkg::ID_W-1:0]    rd_key;
  logic [krd_pkg::PRICE_W-1:0] rd_price;

  logic          ev_valid;
  logic          ev_first;
  logic          ev_last;
  logic [IW-1:0] ev_slot;

  logic [krd_pkg::ID_W-1:0]    best_key;
  logic [krd_pkg::PRICE_W-1:0] best_price;

  logic [krd_pkg::STATUS_W-1:0] res_status;
  logic [krd_pkg::ID_W-1:0]     res_id;
  logic [krd_pkg::PRICE_W-1:0]  res_price;

  logic out_valid;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] f, input logic [CW-1:0] p);
    logic [SW-1:0] sum;
    sum = SW'(f) + SW'(p);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  logic          is_push, is_pop, is_findset, is_max, is_list, full, empty;
  logic          issue, match, better, scan_done;
  logic [IW-1:0] front_dec, front_inc, push_slot, rd_addr, list_slot;
  logic          re, we_push, we_set;

  assign is_push    = (cmd_r == krd_pkg::CMD_PUSH_BACK) || (cmd_r == krd_pkg::CMD_PUSH_FRONT);
  assign is_pop     = (cmd_r == krd_pkg::CMD_POP_FRONT) || (cmd_r == krd_pkg::CMD_POP_BACK);
  assign is_findset = (cmd_r == krd_pkg::CMD_FIND) || (cmd_r == krd_pkg::CMD_SET_PRICE);
  assign is_max     = (cmd_r == krd_pkg::CMD_MAX);
  assign is_list    = (cmd_r == krd_pkg::CMD_LIST_FWD) || (cmd_r == krd_pkg::CMD_LIST_BWD);
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);

  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign push_slot = (cmd_r == krd_pkg::CMD_PUSH_FRONT) ? front_dec : slot_of(front, count);

  assign list_slot = (cmd_r == krd_pkg::CMD_LIST_BWD) ?
                     slot_of(front, count - CW'(1) - pos) : slot_of(front, pos);

  assign match     = ev_valid && is_findset && (rd_key == key_r);
  assign better    = ev_first || ($signed(rd_price) > $signed(best_price));
  assign scan_done = ctrl.scan_run && ev_valid && (match || ev_last);
  assign issue     = ctrl.scan_run && !scan_done && (pos < count);

  assign rd_addr = ctrl.list_rd ? list_slot : slot_of(front, pos);
  assign re      = issue || ctrl.list_rd;
  assign we_push = ctrl.exec && is_push && !full;
  assign we_set  = scan_done && match && (cmd_r == krd_pkg::CMD_SET_PRICE);

  assign stat.is_scan   = is_findset || is_max;
  assign stat.is_list   = is_list;
  assign stat.empty     = empty;
  assign stat.scan_done = scan_done;
  assign stat.list_last = (pos == count);
  assign stat.out_free  = !out_valid || out_ch.ready;

  // ring store
  always_ff @(posedge clk) begin
    if (we_push) begin
      key_mem[push_slot]   <= key_r;
      price_mem[push_slot] <= price_r;
    end else if (we_set) begin
      price_mem[ev_slot] <= price_r;
    end
    if (re) begin
      rd_key   <= key_mem[rd_addr];
      rd_price <= price_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ev_valid <= issue;
      if (ctrl.exec && is_push && !full) begin
        count <= count + CW'(1);
        if (cmd_r == krd_pkg::CMD_PUSH_FRONT) begin
          front <= front_dec;
        end
      end else if (ctrl.exec && is_pop && !empty) begin
        count <= count - CW'(1);
        if (cmd_r == krd_pkg::CMD_POP_FRONT) begin
          front <= front_inc;
        end
      end
      if (ctrl.res_emit || ctrl.list_emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_cmd;
      key_r   <= in_id;
      price_r <= in_price;
    end
    if (ctrl.exec) begin
      pos       <= '0;
      res_id    <= '0;
      res_price <= '0;
      if (is_push) begin
        res_status <= full ? krd_pkg::ST_FULL : krd_pkg::ST_OK;
      end else if (is_pop || is_findset || is_max || is_list) begin
        res_status <= empty ? krd_pkg::ST_EMPTY : krd_pkg::ST_OK;
      end else begin
        res_status <= krd_pkg::ST_OK;
      end
    end else if (issue || ctrl.list_rd) begin
      pos <= pos + CW'(1);
    end
    if (issue) begin
      ev_slot  <= rd_addr;
      ev_first <= (pos == '0);
      ev_last  <= (pos == count - CW'(1));
    end
    if (ctrl.scan_run && ev_valid && is_max && better) begin
      best_key   <= rd_key;
      best_price <= rd_price;
    end
    if (scan_done) begin
      if (is_max) begin
        res_status <= krd_pkg::ST_OK;
        res_id     <= better ? rd_key : best_key;
        res_price  <= better ? rd_price : best_price;
      end else if (match) begin
        res_status <= krd_pkg::ST_OK;
        res_id     <= rd_key;
        res_price  <= (cmd_r == krd_pkg::CMD_SET_PRICE) ? price_r : rd_price;
      end else begin
        res_status <= krd_pkg::ST_NOT_FOUND;
        res_id     <= '0;
        res_price  <= '0;
      end
    end
    if (ctrl.res_emit) begin
      out_ch.status       <= res_status;
      out_ch.out_id       <= res_id;
      out_ch.out_price    <= res_price;
      out_ch.record_count <= krd_pkg::COUNT_W'(count);
      out_ch.last         <= 1'b1;
    end else if (ctrl.list_emit) begin
      out_ch.status       <= krd_pkg::ST_OK;
      out_ch.out_id       <= rd_key;
      out_ch.out_price    <= rd_price;
      out_ch.record_count <= krd_pkg::COUNT_W'(count);
      out_ch.last         <= (pos == count);
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/core/keyed_record_deque.sv =====
// channel  | dir | payload                                           | transfer
// in_ch    | in  | cmd, item_id, item_price                          | valid & ready
// out_ch   | out | status, out_id, out_price, record_count, last     | valid & ready
//
// One command at a time. Push, pop and unused codes pass through the execute and emit states.
// Find, set price and max read one record per cycle from the single-port ring
// store over the n records; a find or set price that hits stops the scan early.
// Listing alternates a store read and an output handshake for each record.
// Synchronous reset empties the queue; a stalled output holds its result and
// the next command is taken once the current one has loaded its last result.
module keyed_record_deque #(
  parameter int DEPTH = krd_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  krd_in_if.sink     in_ch,
  krd_out_if.source  out_ch
);

  krd_pkg::krd_ctrl_t ctrl;
  krd_pkg::krd_stat_t stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  krd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  krd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (in_ch.cmd),
    .in_id    (in_ch.item_id),
    .in_price (in_ch.item_price),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_ch   (out_ch)
  );

endmodule
